// ===== src/vt4x4_pkg.sv =====
// Package for the 4x4 vertex transform: mode codes, status codes and register count.
// No dependencies.
package vt4x4_pkg;

  typedef enum logic [1:0] {
    KIND_PROJ   = 2'd0,
    KIND_AFFINE = 2'd1,
    KIND_DIR    = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_SAT   = 2'd1,
    STATUS_WZERO = 2'd2
  } status_e;

  localparam int unsigned REG_COUNT = 8;
  localparam int unsigned REG_BITS  = 64;
  localparam int unsigned HALF_BITS = 32;
  localparam int unsigned PORT_BITS = 32;

endpackage

// ===== src/vertex_transform_4x4.sv =====
// Throughput: one transaction per cycle; busy_o stays low and the receiver cannot stall.
// The depth is set by the restoring divider, one quotient bit per stage.
// Reset (rst_ni low, asynchronous) clears all valid bits and loads the identity matrix.
// Holds the transform pipeline: input, multiply, sum, offset, divider setup, divider, output.
// Depends on vt4x4_pkg.
module vertex_transform_4x4 #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  kind_i,
  input  logic [31:0] vec_x_i,
  input  logic [31:0] vec_y_i,
  input  logic [31:0] vec_z_i,
  output logic        done_o,
  output logic [31:0] out_x_o,
  output logic [31:0] out_y_o,
  output logic [31:0] out_z_o,
  output logic [1:0]  status_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i
);
  import vt4x4_pkg::*;

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int PW  = 2 * W + 2;
  localparam int FW  = PW - F;
  localparam int SW  = ((FW > W) ? FW : W) + 1;
  localparam int NW  = SW + F;
  localparam int LAT = W + 6;
  localparam logic signed [SW-1:0] MAXV = SW'((64'(1) << (W - 1)) - 64'(1));
  localparam logic signed [SW-1:0] MINV = -MAXV - SW'(1);

  typedef struct packed {
    logic [1:0]            kind;
    logic                  wzero;
    logic [2:0]            neg;
    logic [2:0]            ovf;
    logic [2:0][W-1:0]     aff;
    logic                  affsat;
  } side_t;

  // configuration registers
  logic [REG_BITS-1:0] cfg_q [REG_COUNT];
  logic signed [W-1:0] m [4][4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REG_COUNT; i++) cfg_q[i] <= '0;
      cfg_q[0] <= REG_BITS'(1) << F;
      cfg_q[2] <= REG_BITS'(1) << (F + HALF_BITS);
      cfg_q[5] <= REG_BITS'(1) << F;
      cfg_q[7] <= REG_BITS'(1) << (F + HALF_BITS);
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        m[r][c] = cfg_q[2 * r + c / 2][(c % 2) * HALF_BITS +: W];
      end
    end
  end

  assign busy_o = 1'b0;

  // stage 0: input register
  logic                v0_q;
  logic [1:0]          k0_q;
  logic signed [W-1:0] vec_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else         v0_q <= start_i;
  end

  always_ff @(posedge clk_i) begin
    k0_q     <= kind_i;
    vec_q[0] <= vec_x_i[W-1:0];
    vec_q[1] <= vec_y_i[W-1:0];
    vec_q[2] <= vec_z_i[W-1:0];
  end

  // stage 1: products
  logic                  v1_q;
  logic [1:0]            k1_q;
  logic signed [2*W-1:0] prod_q [3][4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= v0_q;
  end

  always_ff @(posedge clk_i) begin
    k1_q <= k0_q;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        prod_q[r][c] <= vec_q[r] * m[r][c];
      end
    end
  end

  // stage 2: column sums of full products
  logic                 v2_q;
  logic [1:0]           k2_q;
  logic signed [PW-1:0] csum_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    k2_q <= k1_q;
    for (int c = 0; c < 4; c++) begin
      csum_q[c] <= PW'(prod_q[0][c]) + PW'(prod_q[1][c]) + PW'(prod_q[2][c]);
    end
  end

  // stage 3: floor shift and translation
  logic                 v3_q;
  logic [1:0]           k3_q;
  logic signed [SW-1:0] num_q [3];
  logic signed [SW-1:0] w_q;
  logic signed [PW-1:0] fl [4];
  logic                 use_trans;

  always_comb begin
    use_trans = (k2_q == KIND_PROJ) || (k2_q == KIND_AFFINE);
    for (int c = 0; c < 4; c++) fl[c] = csum_q[c] >>> F;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else         v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    k3_q <= k2_q;
    for (int c = 0; c < 3; c++) begin
      num_q[c] <= SW'(fl[c]) + (use_trans ? SW'(m[3][c]) : SW'(0));
    end
    w_q <= SW'(fl[3]) + SW'(m[3][3]);
  end

  // stage 4 onward: divider setup, then one quotient bit per stage
  logic          dv_q   [W+1];
  side_t         side_q [W+1];
  logic [SW-1:0] aw_q   [W+1];
  logic [SW-1:0] rem_q  [W+1][3];
  logic [W-1:0]  nlo_q  [W+1][3];
  logic [W-1:0]  quo_q  [W+1][3];

  side_t         side_d;
  logic [SW-1:0] aw_d;
  logic [SW-1:0] rem_d [3];
  logic [W-1:0]  nlo_d [3];
  logic [SW-1:0] an;
  logic [NW-1:0] nbig;

  always_comb begin
    side_d        = '0;
    side_d.kind   = k3_q;
    side_d.wzero  = (w_q == '0);
    aw_d          = w_q[SW-1] ? SW'(-w_q) : w_q;
    an            = '0;
    nbig          = '0;
    for (int c = 0; c < 3; c++) begin
      an              = num_q[c][SW-1] ? SW'(-num_q[c]) : num_q[c];
      nbig            = NW'(an) << F;
      side_d.neg[c]   = num_q[c][SW-1] ^ w_q[SW-1];
      side_d.ovf[c]   = (nbig >> W) >= NW'(aw_d);
      rem_d[c]        = SW'(nbig >> W);
      nlo_d[c]        = nbig[W-1:0];
      // affine and direction results saturate here
      if (num_q[c] > MAXV) begin
        side_d.aff[c] = MAXV[W-1:0];
        side_d.affsat = 1'b1;
      end else if (num_q[c] < MINV) begin
        side_d.aff[c] = MINV[W-1:0];
        side_d.affsat = 1'b1;
      end else begin
        side_d.aff[c] = num_q[c][W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_q[0] <= 1'b0;
    else         dv_q[0] <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_d;
    aw_q[0]   <= aw_d;
    for (int c = 0; c < 3; c++) begin
      rem_q[0][c] <= rem_d[c];
      nlo_q[0][c] <= nlo_d[c];
      quo_q[0][c] <= '0;
    end
  end

  for (genvar k = 1; k <= W; k++) begin : g_div
    logic [SW:0]   trial [3];
    logic          take  [3];

    always_comb begin
      for (int c = 0; c < 3; c++) begin
        trial[c] = {rem_q[k-1][c], nlo_q[k-1][c][W-1]};
        take[c]  = trial[c] >= {1'b0, aw_q[k-1]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_q[k] <= 1'b0;
      else         dv_q[k] <= dv_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      side_q[k] <= side_q[k-1];
      aw_q[k]   <= aw_q[k-1];
      for (int c = 0; c < 3; c++) begin
        rem_q[k][c] <= take[c] ? SW'(trial[c] - {1'b0, aw_q[k-1]}) : SW'(trial[c]);
        nlo_q[k][c] <= nlo_q[k-1][c] << 1;
        quo_q[k][c] <= {quo_q[k-1][c][W-2:0], take[c]};
      end
    end
  end

  // output stage
  logic                done_q;
  logic [W-1:0]        res_d [3];
  logic [W-1:0]        res_q [3];
  logic [1:0]          status_d;
  logic [1:0]          status_q;
  logic                sat;
  logic [W-1:0]        qv;
  side_t               sf;

  always_comb begin
    sf       = side_q[W];
    sat      = 1'b0;
    qv       = '0;
    status_d = STATUS_OK;
    for (int c = 0; c < 3; c++) res_d[c] = sf.aff[c];
    case (kind_e'(sf.kind))
      KIND_PROJ: begin
        if (sf.wzero) begin
          for (int c = 0; c < 3; c++) res_d[c] = '0;
          status_d = STATUS_WZERO;
        end else begin
          for (int c = 0; c < 3; c++) begin
            qv = quo_q[W][c];
            if (sf.neg[c]) begin
              // magnitude up to 2^(W-1) still fits the negative range
              if (sf.ovf[c] || (qv[W-1] && (qv[W-2:0] != '0))) begin
                res_d[c] = MINV[W-1:0];
                sat      = 1'b1;
              end else begin
                res_d[c] = ~qv + W'(1);
              end
            end else begin
              if (sf.ovf[c] || qv[W-1]) begin
                res_d[c] = MAXV[W-1:0];
                sat      = 1'b1;
              end else begin
                res_d[c] = qv;
              end
            end
          end
          status_d = sat ? STATUS_SAT : STATUS_OK;
        end
      end
      default: begin
        status_d = sf.affsat ? STATUS_SAT : STATUS_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= dv_q[W];
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) res_q[c] <= res_d[c];
    status_q <= status_d;
  end

  assign done_o   = done_q;
  assign out_x_o  = PORT_BITS'($signed(res_q[0]));
  assign out_y_o  = PORT_BITS'($signed(res_q[1]));
  assign out_z_o  = PORT_BITS'($signed(res_q[2]));
  assign status_o = status_q;

`ifndef SYNTH
  a_latency_fwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##LAT done_o)
    else $error("transaction did not complete at the expected latency");

  a_latency_back : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LAT))
    else $error("result strobe without a matching transaction");

  a_wzero_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STATUS_WZERO) |->
      (out_x_o == '0 && out_y_o == '0 && out_z_o == '0))
    else $error("zero w result with nonzero components");

  a_status_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == STATUS_OK || status_o == STATUS_SAT ||
                status_o == STATUS_WZERO))
    else $error("undefined status code");
`endif

endmodule

// ===== verif/tb_top.sv =====
// Testbench for vertex_transform_4x4: directed and random vectors against a
// bit-exact Q16.16 predictor of the homogeneous transform. Depends on vt4x4_pkg.
`timescale 1ns / 1ps

module tb_top;
  import vt4x4_pkg::*;

  localparam int LATENCY = 38;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    status_e     st;
  } vertex_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  kind_i = '0;
  logic [31:0] vec_x_i = '0, vec_y_i = '0, vec_z_i = '0;
  logic        done_o;
  logic [31:0] out_x_o, out_y_o, out_z_o;
  logic [1:0]  status_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [63:0] cfg_wdata_i = '0;

  vertex_t     pending_q[$];
  logic [63:0] matrix_q[REG_COUNT];
  int          fail_cnt = 0;
  int          gap_pct = 0;

  vertex_transform_4x4 dut (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic signed [63:0] entry(int r, int c);
    logic [63:0] rv;
    rv = matrix_q[2 * r + c / 2];
    return (c % 2) ? {{32{rv[63]}}, rv[63:32]} : {{32{rv[31]}}, rv[31:0]};
  endfunction

  // Exact floor of the sum of products shifted by 16; products fit in 64 bits.
  function automatic logic signed [63:0] column_sum(logic signed [63:0] v[3], int c);
    logic signed [95:0] acc;
    acc = 0;
    for (int r = 0; r < 3; r++) acc += 96'(v[r] * entry(r, c));
    return 64'(acc >>> 16);
  endfunction

  function automatic logic signed [63:0] fx_divide(logic signed [63:0] n, logic signed [63:0] w);
    logic        neg;
    logic [63:0] an, aw, q, rem;
    neg = (n < 0) != (w < 0);
    an = (n < 0) ? -n : n;
    aw = (w < 0) ? -w : w;
    q = an / aw;
    rem = an % aw;
    if (q >= 64'h1_0000_0000) begin
      q = 64'h1 << 62;
    end else begin
      for (int i = 0; i < 16; i++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= aw) begin
          rem -= aw;
          q[0] = 1'b1;
        end
      end
    end
    return neg ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic [31:0] clamp(logic signed [63:0] s, inout logic sat);
    if (s > 64'sh7FFF_FFFF) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (s < -64'sh8000_0000) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return s[31:0];
  endfunction

  function automatic vertex_t transform(logic [1:0] k, logic [31:0] x, logic [31:0] y,
                                        logic [31:0] z);
    logic signed [63:0] v[3];
    logic signed [63:0] s[3];
    logic signed [63:0] w;
    logic [31:0]        r[3];
    logic               sat;
    vertex_t            res;
    v[0] = $signed(x);
    v[1] = $signed(y);
    v[2] = $signed(z);
    sat = 1'b0;
    w = column_sum(v, 3) + entry(3, 3);
    if (k == KIND_PROJ && w == 0) begin
      res = '{x: '0, y: '0, z: '0, st: STATUS_WZERO};
    end else begin
      for (int c = 0; c < 3; c++) begin
        s[c] = column_sum(v, c);
        if (k == KIND_PROJ) s[c] = fx_divide(s[c] + entry(3, c), w);
        else if (k == KIND_AFFINE) s[c] += entry(3, c);
        r[c] = clamp(s[c], sat);
      end
      res = '{x: r[0], y: r[1], z: r[2], st: sat ? STATUS_SAT : STATUS_OK};
    end
    return res;
  endfunction

  // Hold start high between back-to-back transactions; drop it only while idling.
  task automatic send_vertex(logic [1:0] k, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    while ($urandom_range(99) < gap_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    kind_i <= k;
    vec_x_i <= x;
    vec_y_i <= y;
    vec_z_i <= z;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_q.push_back(transform(k, x, y, z));
    @(negedge clk_i);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  task automatic write_matrix(int idx, logic [63:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx[2:0];
    cfg_wdata_i <= val;
    matrix_q[idx] = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(32'h0002_0000) - 32'h0001_0000;
      3: return {{16{$urandom_range(1) == 1}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(3))
      0: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
      1: return {{16{$urandom_range(1) == 1}}, 16'($urandom)};
      2: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_identity();
    send_vertex(KIND_PROJ, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000);
    send_vertex(KIND_AFFINE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    send_vertex(KIND_DIR, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_vertex(2'd3, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0000_0001);
    drain();
  endtask

  task automatic test_extremes();
    for (int i = 0; i < REG_COUNT; i++) write_matrix(i, 64'h7FFF_FFFF_8000_0000);
    send_vertex(KIND_PROJ, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_vertex(KIND_AFFINE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vertex(KIND_DIR, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_vertex(KIND_PROJ, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    drain();
  endtask

  task automatic test_zero_w();
    for (int i = 0; i < REG_COUNT; i++) write_matrix(i, 64'h0);
    write_matrix(0, 64'h0000_0001_0002_0000);
    send_vertex(KIND_PROJ, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    send_vertex(KIND_AFFINE, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    drain();
    write_matrix(7, 64'h0000_0001_0000_0000);
    send_vertex(KIND_PROJ, 32'h0100_0000, 32'h0, 32'h0);
    send_vertex(KIND_PROJ, 32'hFF00_0000, 32'h0, 32'h0);
    drain();
  endtask

  task automatic test_random(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        if (p % 3 == 0 && i == 7) write_matrix(i, {($urandom_range(1) ? 32'h0001_0000
                                                         : rand_entry()), rand_entry()});
        else write_matrix(i, {rand_entry(), rand_entry()});
      end
      for (int n = 0; n < per_phase; n++)
        send_vertex(2'($urandom_range(3)), rand_word(), rand_word(), rand_word());
      drain();
    end
  endtask

  always @(posedge clk_i) begin
    vertex_t exp_v;
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result x=%h", out_x_o);
        fail_cnt++;
      end else begin
        exp_v = pending_q.pop_front();
        if (out_x_o !== exp_v.x) begin
          $error("out_x expected %h actual %h", exp_v.x, out_x_o);
          fail_cnt++;
        end
        if (out_y_o !== exp_v.y) begin
          $error("out_y expected %h actual %h", exp_v.y, out_y_o);
          fail_cnt++;
        end
        if (out_z_o !== exp_v.z) begin
          $error("out_z expected %h actual %h", exp_v.z, out_z_o);
          fail_cnt++;
        end
        if (status_o !== exp_v.st) begin
          $error("status expected %0d actual %0d", exp_v.st, status_o);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  initial begin
    matrix_q = '{64'h0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
                 64'h0, 64'h0001_0000, 64'h0, 64'h0001_0000_0000_0000};
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_identity();
    test_extremes();
    test_zero_w();
    gap_pct = 15;
    test_random(5, 100);
    gap_pct = 76;
    test_random(5, 100);
    gap_pct = 0;
    test_random(5, 100);
    if (fail_cnt == 0 && pending_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
